/* design/usvg_pkg.sv */
// usvg_pkg: shared constants, types and helper functions of the uv sphere vertex generator
// no dependencies; imported by every module of the block
package usvg_pkg;

  localparam int unsigned CfgW = 9;

  // register indexes on the configuration port
  localparam logic RegRingSegments = 1'b0;
  localparam logic RegRingCount    = 1'b1;

  localparam logic [CfgW-1:0] ResetSegments = 9'd20;
  localparam logic [CfgW-1:0] ResetCount    = 9'd20;
  localparam logic [CfgW-1:0] MaxSegments   = 9'd256;
  localparam logic [CfgW-1:0] MinSegments   = 9'd2;
  localparam logic [CfgW-1:0] MinCount      = 9'd1;

  // divider: integer step plus fractional steps, seven steps per stage
  localparam int unsigned DivStages = 5;
  localparam int unsigned DivSteps  = 7;
  localparam int unsigned QuotW     = DivStages * DivSteps;   // 35 quotient bits
  localparam int unsigned RemW      = CfgW + 1;

  // cordic
  localparam int unsigned CW          = 34;
  localparam int unsigned CordicSteps = 30;
  localparam int unsigned CordicPer   = 2;
  localparam int unsigned CordicStgs  = CordicSteps / CordicPer;
  localparam logic [30:0] HalfPiQ30   = 31'd1686629713;
  localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CW-1:0] OneQ30     = 34'sd1073741824;

  localparam logic signed [19:0] Q14Max = 20'sd16384;
  localparam logic [16:0]        UOne   = 17'd65536;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // result fields that travel beside the trig pipeline
  typedef struct packed {
    logic        seam;
    logic        tris;
    logic [16:0] u;
    logic [16:0] v;
    logic [15:0] here;
    logic [15:0] nxt;
    logic [15:0] below;
    logic [15:0] diag;
  } side_t;

  function automatic logic signed [CW-1:0] atan_q30(input int unsigned k);
    logic signed [CW-1:0] a;
    case (k)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      24: a = 34'sd63;
      25: a = 34'sd31;
      26: a = 34'sd15;
      27: a = 34'sd7;
      28: a = 34'sd3;
      29: a = 34'sd1;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

  // one rotation, shifts round toward minus infinity
  function automatic cordic_t cordic_iter(input cordic_t a, input int unsigned k);
    cordic_t r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = a.y >>> k;
    dy = a.x >>> k;
    if (a.z >= 0) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - atan_q30(k);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + atan_q30(k);
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_q14(input logic signed [19:0] v);
    logic signed [19:0] r;
    if (v > Q14Max) r = Q14Max;
    else if (v < -Q14Max) r = -Q14Max;
    else r = v;
    return r[15:0];
  endfunction

endpackage

/* design/usvg_div.sv */
// usvg_div: pipelined restoring divider, q = floor(a * 2^34 / d) for a <= d
// depends on usvg_pkg; stage enables come from the top level
module usvg_div (
  input  logic                          clk_i,
  input  logic [usvg_pkg::DivStages-1:0] en_i,
  input  logic [usvg_pkg::CfgW-1:0]     a_i,
  input  logic [usvg_pkg::CfgW-1:0]     d_i,
  output logic [usvg_pkg::QuotW-1:0]    q_o
);
  import usvg_pkg::*;

  logic [RemW-1:0]  rem_q [DivStages];
  logic [QuotW-1:0] quo_q [DivStages];
  logic [CfgW-1:0]  dvs_q [DivStages];
  logic [RemW-1:0]  rem_d [DivStages];
  logic [QuotW-1:0] quo_d [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    always_comb begin
      logic [RemW-1:0]  r;
      logic [QuotW-1:0] q;
      logic [CfgW-1:0]  d;
      if (s == 0) begin
        d = d_i;
        r = {1'b0, a_i};
        q = '0;
        // integer bit
        if (r >= {1'b0, d}) begin
          r = r - {1'b0, d};
          q = {{(QuotW-1){1'b0}}, 1'b1};
        end
        for (int k = 1; k < DivSteps; k++) begin
          r = {r[RemW-2:0], 1'b0};
          if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q = {q[QuotW-2:0], 1'b1};
          end else begin
            q = {q[QuotW-2:0], 1'b0};
          end
        end
      end else begin
        d = dvs_q[(s == 0) ? 0 : s-1];
        r = rem_q[(s == 0) ? 0 : s-1];
        q = quo_q[(s == 0) ? 0 : s-1];
        for (int k = 0; k < DivSteps; k++) begin
          r = {r[RemW-2:0], 1'b0};
          if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q = {q[QuotW-2:0], 1'b1};
          end else begin
            q = {q[QuotW-2:0], 1'b0};
          end
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        dvs_q[s] <= (s == 0) ? d_i : dvs_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign q_o = quo_q[DivStages-1];

endmodule

/* design/usvg_sincos.sv */
// usvg_sincos: pipelined cosine and sine in q30 of an angle in 2^-32 turns
// depends on usvg_pkg; one angle stage, fifteen cordic stages, one quadrant stage
module usvg_sincos (
  input  logic                                clk_i,
  input  logic [usvg_pkg::CordicStgs+1:0]     en_i,
  input  logic [31:0]                         t_i,
  output logic signed [usvg_pkg::CW-1:0]      c_o,
  output logic signed [usvg_pkg::CW-1:0]      s_o
);
  import usvg_pkg::*;

  cordic_t    cor_q  [CordicStgs+1];
  cordic_t    cor_d  [CordicStgs+1];
  logic [1:0] quad_q [CordicStgs+1];
  logic       zero_q [CordicStgs+1];
  logic signed [CW-1:0] c_q, s_q;

  // angle stage: fraction of a quadrant to radians q30
  always_comb begin
    logic [60:0] prod;
    prod = {31'b0, t_i[29:0]} * {30'b0, HalfPiQ30} + 61'd536870912;
    cor_d[0].x = CordicGain;
    cor_d[0].y = '0;
    cor_d[0].z = {3'b000, prod[60:30]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cor_q[0]  <= cor_d[0];
      quad_q[0] <= t_i[31:30];
      zero_q[0] <= (t_i[29:0] == 30'd0);
    end
  end

  for (genvar s = 1; s <= CordicStgs; s++) begin : g_cordic
    always_comb begin
      cordic_t a;
      a = cor_q[s-1];
      for (int k = 0; k < CordicPer; k++) begin
        a = cordic_iter(a, (s-1)*CordicPer + k);
      end
      cor_d[s] = a;
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        cor_q[s]  <= cor_d[s];
        quad_q[s] <= quad_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] cx, sy;
    if (en_i[CordicStgs+1]) begin
      cx = zero_q[CordicStgs] ? OneQ30 : cor_q[CordicStgs].x;
      sy = zero_q[CordicStgs] ? '0 : cor_q[CordicStgs].y;
      case (quad_q[CordicStgs])
        2'd0:    begin c_q <= cx;  s_q <= sy;  end
        2'd1:    begin c_q <= -sy; s_q <= cx;  end
        2'd2:    begin c_q <= -cx; s_q <= -sy; end
        default: begin c_q <= sy;  s_q <= -cx; end
      endcase
    end
  end

  assign c_o = c_q;
  assign s_o = s_q;

endmodule

/* design/uv_sphere_vertex_generator.sv */
// uv_sphere_vertex_generator: top level, config registers, stage control and sideband
// depends on usvg_pkg, usvg_div and usvg_sincos
//
// usage
// - input channel: in_valid_i/in_ready_o carry one grid position (col_index_i, row_index_i)
//   per transaction; out of range positions saturate to the clamped m and n
// - output channel: out_valid_o/out_ready_i carry one vertex per transaction: position in
//   q1.14, texture coordinates in q1.16, four corner indices and the triangle flag
// - configuration: apb-style port, ring_segments at address 0, ring_count at address 4,
//   pready always high; write only while the block holds no transaction in flight
// - throughput: one transaction per cycle unless the output stalls; the 26 register stages
//   (input clamp, 5 divider stages, one angle stage, 17 sin/cos stages: angle scaling, 15
//   with two cordic rotations each and the quadrant fold, one multiply stage, one
//   rounding/output stage) each take a new item every cycle when not stalled
// - stall: a stage advances when it is empty or the stage after it advances, so bubbles
//   are squeezed out and input is still taken while the output waits, until all stages
//   are full
// - reset: all stage valid bits clear, both registers return to 20
module uv_sphere_vertex_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb-style configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [8:0]  col_index_i,
  input  logic [8:0]  row_index_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [16:0] tex_u_o,
  output logic [16:0] tex_v_o,
  output logic [15:0] corner_here_o,
  output logic [15:0] corner_next_o,
  output logic [15:0] corner_below_o,
  output logic [15:0] corner_diag_o,
  output logic        tris_valid_o
);
  import usvg_pkg::*;

  // stage map
  localparam int unsigned StAng  = DivStages + 1;        // angles, u and v
  localparam int unsigned StSc0  = StAng + 1;            // first sin/cos stage
  localparam int unsigned StScN  = StSc0 + CordicStgs + 1;
  localparam int unsigned StMul  = StScN + 1;
  localparam int unsigned StOut  = StMul + 1;
  localparam int unsigned NumSt  = StOut + 1;

  // configuration registers
  logic [CfgW-1:0] ring_segments_q, ring_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_segments_q <= ResetSegments;
      ring_count_q    <= ResetCount;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegRingSegments: ring_segments_q <= pwdata[CfgW-1:0];
        RegRingCount:    ring_count_q    <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegRingSegments: prdata = {{(32-CfgW){1'b0}}, ring_segments_q};
      RegRingCount:    prdata = {{(32-CfgW){1'b0}}, ring_count_q};
      default:         prdata = '0;
    endcase
  end
  assign pready = 1'b1;

  // stage valid bits and per-stage advance
  logic [NumSt-1:0] v_q, en;

  always_comb begin
    en[NumSt-1] = !v_q[NumSt-1] || out_ready_i;
    for (int s = NumSt-2; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int s = 0; s < NumSt; s++) begin
        if (en[s]) v_q[s] <= (s == 0) ? in_valid_i : v_q[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[StOut];

  // stage 0: clamp registers and inputs
  logic [CfgW-1:0] m_lim, n_lim;
  logic [CfgW-1:0] i0_q, j0_q, m0_q, n0_q;

  always_comb begin
    if (ring_segments_q < MinSegments)      m_lim = MinSegments;
    else if (ring_segments_q > MaxSegments) m_lim = MaxSegments;
    else                                    m_lim = ring_segments_q;
    if (ring_count_q < MinCount)            n_lim = MinCount;
    else if (ring_count_q > MaxSegments)    n_lim = MaxSegments;
    else                                    n_lim = ring_count_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      i0_q <= (col_index_i > m_lim) ? m_lim : col_index_i;
      j0_q <= (row_index_i > n_lim) ? n_lim : row_index_i;
      m0_q <= m_lim;
      n0_q <= n_lim;
    end
  end

  // dividers, stages 1 to DivStages: i/m and j/n as fractions with 34 bits
  logic [QuotW-1:0] qi, qj;

  usvg_div u_div_col (
    .clk_i (clk_i),
    .en_i  (en[DivStages:1]),
    .a_i   (i0_q),
    .d_i   (m0_q),
    .q_o   (qi)
  );

  usvg_div u_div_row (
    .clk_i (clk_i),
    .en_i  (en[DivStages:1]),
    .a_i   (j0_q),
    .d_i   (n0_q),
    .q_o   (qj)
  );

  // sideband: corners and flags at stage 1, u and v joined at the angle stage
  side_t side_q [NumSt];
  side_t side_d [NumSt];

  always_comb begin
    logic [CfgW-1:0] w;
    logic [17:0]     jw;
    logic [15:0]     here, nxt;
    logic [18:0]     ui, vj;
    w    = m0_q + 9'd1;
    jw   = {9'b0, j0_q} * {9'b0, w};
    here = jw[15:0] + {7'b0, i0_q};
    nxt  = jw[15:0] + ((i0_q == m0_q) ? 16'd0 : {7'b0, i0_q} + 16'd1);
    // round half up: floor(2x) then (f + 1) / 2
    ui = {1'b0, qi[QuotW-1:17]} + 19'd1;
    vj = {1'b0, qj[QuotW-1:17]} + 19'd1;
    for (int s = 2; s < NumSt; s++) begin
      side_d[s] = side_q[s-1];
    end
    side_d[1].seam  = (i0_q == m0_q);
    side_d[1].tris  = (j0_q < n0_q);
    side_d[1].u     = '0;
    side_d[1].v     = '0;
    side_d[1].here  = here;
    side_d[1].nxt   = nxt;
    side_d[1].below = here + {7'b0, w};
    side_d[1].diag  = nxt + {7'b0, w};
    side_d[StAng].u = side_q[StAng-1].seam ? UOne : ui[17:1];
    side_d[StAng].v = vj[17:1];
  end

  always_ff @(posedge clk_i) begin
    for (int s = 1; s < NumSt; s++) begin
      if (en[s]) side_q[s] <= side_d[s];
    end
  end

  // angle stage: turns in 2^-32 units
  logic [31:0] theta_q, phi_q;

  always_ff @(posedge clk_i) begin
    logic [33:0] th, ph;
    if (en[StAng]) begin
      th = qi[QuotW-1:1] + 34'd1;
      ph = {1'b0, qj[QuotW-1:2]} + 34'd1;
      theta_q <= th[32:1];
      phi_q   <= ph[32:1];
    end
  end

  // sin/cos pipelines
  logic signed [CW-1:0] ct, st, cp, sp;

  usvg_sincos u_sc_theta (
    .clk_i (clk_i),
    .en_i  (en[StScN:StSc0]),
    .t_i   (theta_q),
    .c_o   (ct),
    .s_o   (st)
  );

  usvg_sincos u_sc_phi (
    .clk_i (clk_i),
    .en_i  (en[StScN:StSc0]),
    .t_i   (phi_q),
    .c_o   (cp),
    .s_o   (sp)
  );

  // multiply stage
  logic signed [63:0] px_q, py_q;
  logic signed [31:0] cp_q, sp_q;

  always_ff @(posedge clk_i) begin
    if (en[StMul]) begin
      px_q <= $signed(ct[31:0]) * $signed(sp[31:0]);
      py_q <= $signed(st[31:0]) * $signed(sp[31:0]);
      cp_q <= cp[31:0];
      sp_q <= sp[31:0];
    end
  end

  // rounding, saturation and seam override into the output register
  logic signed [15:0] x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    logic signed [63:0] rx, ry;
    logic signed [32:0] rs, rc;
    if (en[StOut]) begin
      rx = px_q + 64'sh0000_2000_0000_0000;
      ry = py_q + 64'sh0000_2000_0000_0000;
      rs = {sp_q[31], sp_q} + 33'sd32768;
      rc = {cp_q[31], cp_q} + 33'sd32768;
      if (side_q[StMul].seam) begin
        x_q <= sat_q14({{3{rs[32]}}, rs[32:16]});
        y_q <= '0;
      end else begin
        x_q <= sat_q14({{2{rx[63]}}, rx[63:46]});
        y_q <= sat_q14({{2{ry[63]}}, ry[63:46]});
      end
      z_q <= sat_q14({{3{rc[32]}}, rc[32:16]});
    end
  end

  assign pos_x_o        = x_q;
  assign pos_y_o        = y_q;
  assign pos_z_o        = z_q;
  assign tex_u_o        = side_q[StOut].u;
  assign tex_v_o        = side_q[StOut].v;
  assign corner_here_o  = side_q[StOut].here;
  assign corner_next_o  = side_q[StOut].nxt;
  assign corner_below_o = side_q[StOut].below;
  assign corner_diag_o  = side_q[StOut].diag;
  assign tris_valid_o   = side_q[StOut].tris;

  // only the seam column reaches u = 1.0, and there y is forced to zero
  a_seam_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (tex_u_o == UOne) |-> pos_y_o == 16'sd0)
    else $error("seam vertex with nonzero y");

  // the last ring has no triangles and sits at v = 1.0
  a_last_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tris_valid_o |-> tex_v_o == UOne)
    else $error("last ring with v below one");

  // z never leaves the q1.14 unit range
  a_z_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pos_z_o <= 16'sd16384) && (pos_z_o >= -16'sd16384))
    else $error("z outside unit range");

  // items in flight change by at most one per cycle
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ($countones(v_q) <= $past($countones(v_q)) + 1) &&
        ($countones(v_q) + 1 >= $past($countones(v_q))))
    else $error("pipeline occupancy jumped");

  // a held output stage keeps its result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[StOut] && !out_ready_i |=> v_q[StOut] && $stable(x_q) && $stable(side_q[StOut]))
    else $error("stalled result changed");

endmodule

/* verif/usvg_checker.sv */
// usvg_checker: watches the config port and both channels of the uv sphere vertex generator,
// predicts each vertex and compares it; depends on usvg_pkg for register indexes
module usvg_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [8:0]  col_index_i,
  input  logic [8:0]  row_index_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [15:0] pos_z_i,
  input  logic [16:0] tex_u_i,
  input  logic [16:0] tex_v_i,
  input  logic [15:0] corner_here_i,
  input  logic [15:0] corner_next_i,
  input  logic [15:0] corner_below_i,
  input  logic [15:0] corner_diag_i,
  input  logic        tris_valid_i,
  output int          pending_o,
  output int          fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import usvg_pkg::*;

  typedef struct {
    logic [15:0] x, y, z;
    logic [16:0] u, v;
    logic [15:0] here, nxt, below, diag;
    logic        tris;
  } vertex_t;

  localparam longint AtanTab [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1};

  logic [8:0] segments_q, count_q;
  vertex_t    vertex_q[$];
  int         fails;

  assign pending_o    = vertex_q.size();
  assign fail_count_o = fails;

  function automatic longint round_q14(longint v, int k);
    longint r;
    r = (v + (longint'(1) << (k - 1))) >>> k;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // cos and sin in q30 of an angle in 2^-32 turns
  function automatic void turn_trig(logic [31:0] t, output longint c, output longint s);
    logic [29:0] r;
    longint cx, sy, x, y, z, dx, dy;
    r = t[29:0];
    if (r == 0) begin
      cx = longint'(1) << 30;
      sy = 0;
    end else begin
      z = longint'((longint'(r) * 64'd1686629713 + (64'd1 << 29)) >> 30);
      x = 652032874;
      y = 0;
      for (int k = 0; k < 30; k++) begin
        dx = y >>> k;
        dy = x >>> k;
        if (z >= 0) begin
          x -= dx; y += dy; z -= AtanTab[k];
        end else begin
          x += dx; y -= dy; z += AtanTab[k];
        end
      end
      cx = x;
      sy = y;
    end
    case (t[31:30])
      2'd0: begin c = cx;  s = sy;  end
      2'd1: begin c = -sy; s = cx;  end
      2'd2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
  endfunction

  function automatic vertex_t predict_vertex(logic [8:0] col, logic [8:0] row);
    vertex_t e;
    longint unsigned m, n, i, j, w, here, nxt;
    longint ct, st, cp, sp;
    logic [31:0] th, ph;
    m = segments_q;
    n = count_q;
    if (m < 2) m = 2;
    if (m > 256) m = 256;
    if (n < 1) n = 1;
    if (n > 256) n = 256;
    i = (col > m) ? m : col;
    j = (row > n) ? n : row;
    th = 32'(((i << 33) + m) / (2 * m));
    ph = 32'(((j << 32) + n) / (2 * n));
    turn_trig(th, ct, st);
    turn_trig(ph, cp, sp);
    if (i == m) begin
      e.x = 16'(round_q14(sp, 16));
      e.y = 0;
      e.u = 17'd65536;
    end else begin
      e.x = 16'(round_q14(ct * sp, 46));
      e.y = 16'(round_q14(st * sp, 46));
      e.u = 17'(((i << 17) + m) / (2 * m));
    end
    e.z = 16'(round_q14(cp, 16));
    e.v = 17'(((j << 17) + n) / (2 * n));
    w = m + 1;
    here = j * w + i;
    nxt = j * w + ((i + 1) % w);
    e.here  = 16'(here);
    e.nxt   = 16'(nxt);
    e.below = 16'(here + w);
    e.diag  = 16'(nxt + w);
    e.tris  = (j < n);
    return e;
  endfunction

  task automatic check_field(string name, logic [16:0] expv, logic [16:0] act);
    if (expv !== act) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, act);
      fails++;
    end
  endtask

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_t e;
    if (!rst_ni) begin
      segments_q <= 9'd20;
      count_q    <= 9'd20;
      vertex_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegRingSegments) segments_q <= pwdata[8:0];
        else count_q <= pwdata[8:0];
      end
      if (in_valid_i && in_ready_i) begin
        vertex_q = {vertex_q, predict_vertex(col_index_i, row_index_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected output transaction");
          fails++;
        end else begin
          e = vertex_q.pop_front();
          check_field("pos_x", e.x, pos_x_i);
          check_field("pos_y", e.y, pos_y_i);
          check_field("pos_z", e.z, pos_z_i);
          check_field("tex_u", e.u, tex_u_i);
          check_field("tex_v", e.v, tex_v_i);
          check_field("corner_here", e.here, corner_here_i);
          check_field("corner_next", e.nxt, corner_next_i);
          check_field("corner_below", e.below, corner_below_i);
          check_field("corner_diag", e.diag, corner_diag_i);
          check_field("tris_valid", e.tris, tris_valid_i);
        end
      end
    end
  end
endmodule

/* verif/tb_uv_sphere_vertex_generator.sv */
// tb_uv_sphere_vertex_generator: stimulus, config phases and verdict for the vertex generator
// depends on usvg_pkg, uv_sphere_vertex_generator and usvg_checker
module tb_uv_sphere_vertex_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import usvg_pkg::*;

  localparam int Latency = 25;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o;
  logic [8:0] col_index_i = '0, row_index_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic signed [15:0] pos_x_o, pos_y_o, pos_z_o;
  logic [16:0] tex_u_o, tex_v_o;
  logic [15:0] corner_here_o, corner_next_o, corner_below_o, corner_diag_o;
  logic tris_valid_o;
  int pending, fail_count, cycles = 0;
  logic sender_steady = 1'b0;   // no gaps between input transactions
  logic sink_steady = 1'b0;     // receiver never stalls
  logic hold_req = 1'b0;        // ask the receiver for one long stall
  int m_cur, n_cur;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  uv_sphere_vertex_generator DUT (.*);

  usvg_checker u_checker (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_i(in_ready_o), .col_index_i, .row_index_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .pos_z_i(pos_z_o),
    .tex_u_i(tex_u_o), .tex_v_i(tex_v_o),
    .corner_here_i(corner_here_o), .corner_next_i(corner_next_o),
    .corner_below_i(corner_below_o), .corner_diag_i(corner_diag_o),
    .tris_valid_i(tris_valid_o), .pending_o(pending), .fail_count_o(fail_count)
  );

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls per transaction, one long hold-off on request
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        // block fills up and backpressures the input while we hold
        out_ready_i <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req <= 1'b0;
      end
      gap = sink_steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // one input transaction, with a random gap before it
  task automatic send_pos(logic [8:0] col, logic [8:0] row);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    col_index_i <= col;
    row_index_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drain, let the pipeline settle, then write one register over apb
  task automatic write_reg(logic idx, logic [8:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {23'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegRingSegments) m_cur = (val < 2) ? 2 : (val > 256) ? 256 : val;
    else n_cur = (val < 1) ? 1 : (val > 256) ? 256 : val;
  endtask

  // random grid positions, mostly legal, some saturating
  task automatic random_burst(int count);
    logic [8:0] c, r;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        c = 9'($urandom);
        r = 9'($urandom);
      end else begin
        c = 9'($urandom_range(0, m_cur));
        r = 9'($urandom_range(0, n_cur));
      end
      if (k % 40 == 20) begin
        sender_steady <= ($urandom_range(0, 2) == 0);
        sink_steady   <= ($urandom_range(0, 2) == 0);
      end
      send_pos(c, r);
    end
    sender_steady <= 1'b0;
    sink_steady   <= 1'b0;
  endtask

  initial begin
    int seg_tab[6] = '{2, 256, 0, 511, 3, 100};
    int cnt_tab[6] = '{1, 256, 0, 511, 7, 200};
    m_cur = 20;
    n_cur = 20;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: poles, seam, quadrant boundaries, saturation, all-ones inputs
    send_pos(0, 0);     send_pos(20, 0);   send_pos(0, 20);   send_pos(20, 20);
    send_pos(5, 10);    send_pos(10, 10);  send_pos(15, 10);  send_pos(19, 19);
    send_pos(1, 1);     send_pos(20, 10);  send_pos(21, 21);  send_pos(511, 511);
    send_pos(256, 0);   send_pos(0, 256);  send_pos(7, 3);    send_pos(13, 17);
    send_pos(10, 5);    send_pos(10, 15);  send_pos(3, 20);   send_pos(20, 1);
    random_burst(40);

    // long receiver hold while input keeps coming
    hold_req <= 1'b1;
    random_burst(60);

    // register sweep: minimum, maximum, out of range low and high, odd, asymmetric
    for (int p = 0; p < 6; p++) begin
      write_reg(RegRingSegments, 9'(seg_tab[p]));
      write_reg(RegRingCount, 9'(cnt_tab[p]));
      send_pos(0, 0);
      send_pos(9'(m_cur), 9'(n_cur));
      send_pos(9'(m_cur - 1), 9'(n_cur - 1));
      send_pos(9'h1ff, 9'h1ff);
      random_burst(60);
    end

    // final phase at random legal settings
    write_reg(RegRingSegments, 9'($urandom_range(2, 256)));
    write_reg(RegRingCount, 9'($urandom_range(1, 256)));
    random_burst(50);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
